// ===== hdl/fckd_pkg.sv =====
// Shared types, keyword table and codes for the framed command keyword decoder.
package fckd_pkg;

  // Frame delimiters
  localparam logic [7:0] BYTE_START = 8'h24;  // '$'
  localparam logic [7:0] BYTE_END   = 8'h23;  // '#'

  // Default configuration
  localparam int unsigned MAX_LEN_DEFAULT     = 20;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // Output field widths
  localparam int unsigned CMD_W = 3;
  localparam int unsigned LEN_W = 5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_UNKNOWN   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GOBACK    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GOAHEAD   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TURNLEFT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TURNRIGHT = 3'd4;

  // Keyword table: keyword k, character position p
  localparam int unsigned KW_COUNT = 4;
  localparam int unsigned KW_MAX   = 9;
  localparam int unsigned POS_W    = 4;

  localparam logic [KW_COUNT-1:0][KW_MAX-1:0][7:0] KW_TEXT = '{
    '{8'h74, 8'h68, 8'h67, 8'h69, 8'h72, 8'h6e, 8'h72, 8'h75, 8'h74},  // turnright
    '{8'h00, 8'h74, 8'h66, 8'h65, 8'h6c, 8'h6e, 8'h72, 8'h75, 8'h74},  // turnleft
    '{8'h00, 8'h00, 8'h64, 8'h61, 8'h65, 8'h68, 8'h61, 8'h6f, 8'h67},  // goahead
    '{8'h00, 8'h00, 8'h00, 8'h6b, 8'h63, 8'h61, 8'h62, 8'h6f, 8'h67}   // goback
  };

  localparam logic [KW_COUNT-1:0][POS_W-1:0] KW_LEN = '{4'd9, 4'd8, 4'd7, 4'd6};

  // Kind of a received byte, as seen by the classifier
  typedef enum logic [1:0] {
    KIND_START,
    KIND_END,
    KIND_DATA
  } kind_e;

  // Entry of the queue between classifier and frame engine
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } item_t;

  // Frame engine state
  typedef enum logic {
    ST_IDLE,
    ST_FRAME
  } state_e;

  // Character of keyword k at position pos; zero past the table
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [POS_W-1:0] pos);
    logic [7:0] c;
    c = 8'h00;
    if (pos < POS_W'(KW_MAX)) begin
      c = KW_TEXT[k][pos];
    end
    return c;
  endfunction

endpackage

// ===== hdl/fckd_front.sv =====
// Front end: accepts received bytes and classifies them for the queue.
module fckd_front (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output fckd_pkg::item_t    q_item_o
);
  import fckd_pkg::*;

  // Take an item whenever the queue has room
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classify the byte by value
  always_comb begin
    q_item_o.data = rx_byte_i;
    if (rx_byte_i == BYTE_START) begin
      q_item_o.kind = KIND_START;
    end else if (rx_byte_i == BYTE_END) begin
      q_item_o.kind = KIND_END;
    end else begin
      q_item_o.kind = KIND_DATA;
    end
  end

endmodule

// ===== hdl/fckd_queue.sv =====
// Small register FIFO that decouples the classifier from the frame engine.
module fckd_queue #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o,
  input  logic             pop_i
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hdl/fckd_back.sv =====
// Frame engine: tracks framing, matches keywords on the fly, holds the result.
module fckd_back #(
  parameter int unsigned MAX_LEN = fckd_pkg::MAX_LEN_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  fckd_pkg::item_t             q_item_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [fckd_pkg::CMD_W-1:0]  command_o,
  output logic [fckd_pkg::LEN_W-1:0]  message_length_o
);
  import fckd_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [POS_W-1:0]     text_len_q, text_len_d;
  logic                 zero_seen_q, zero_seen_d;
  logic [KW_COUNT-1:0]  match_q, match_d;
  logic                 out_valid_q, out_valid_d;
  logic [CMD_W-1:0]     out_cmd_q, out_cmd_d;
  logic [LEN_W-1:0]     out_len_q, out_len_d;

  logic is_close;
  logic is_full;
  logic [CMD_W-1:0] cmd_sel;

  assign is_close = (state_q == ST_FRAME) && (q_item_i.kind == KIND_END);
  assign is_full  = (count_q >= CNT_W'(MAX_LEN));

  // Take a queued item unless it closes a frame and the result slot is blocked
  assign q_pop_o = q_valid_i && (!is_close || !out_valid_q || out_ready_i);

  // Pick the keyword whose prefix matched and whose length fits exactly
  always_comb begin
    cmd_sel = CMD_UNKNOWN;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (match_q[k] && text_len_q == KW_LEN[k]) begin
        cmd_sel = CMD_W'(k + 1);
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    if (q_pop_o) begin
      case (state_q)
        ST_IDLE: begin
          if (q_item_i.kind == KIND_START) begin
            state_d = ST_FRAME;
          end
        end
        ST_FRAME: begin
          if (q_item_i.kind == KIND_END) begin
            state_d = ST_IDLE;
          end else if (q_item_i.kind == KIND_DATA && is_full) begin
            state_d = ST_IDLE;
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  // Frame datapath and result register
  always_comb begin
    count_d     = count_q;
    text_len_d  = text_len_q;
    zero_seen_d = zero_seen_q;
    match_d     = match_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_cmd_d   = out_cmd_q;
    out_len_d   = out_len_q;
    if (q_pop_o) begin
      case (state_q)
        ST_IDLE: begin
          if (q_item_i.kind == KIND_START) begin
            count_d     = '0;
            text_len_d  = '0;
            zero_seen_d = 1'b0;
            match_d     = '1;
          end
        end
        ST_FRAME: begin
          if (q_item_i.kind == KIND_END) begin
            out_valid_d = 1'b1;
            out_cmd_d   = cmd_sel;
            out_len_d   = LEN_W'(count_q);
            count_d     = '0;
          end else if (q_item_i.kind == KIND_DATA) begin
            if (is_full) begin
              // Drop the overlong frame
              count_d = '0;
            end else begin
              count_d = count_q + CNT_W'(1);
              if (!zero_seen_q) begin
                if (q_item_i.data == 8'h00) begin
                  zero_seen_d = 1'b1;
                end else begin
                  for (int k = 0; k < KW_COUNT; k++) begin
                    match_d[k] = match_q[k] &&
                                 (kw_char(2'(k), text_len_q) == q_item_i.data);
                  end
                  if (text_len_q != '1) begin
                    text_len_d = text_len_q + POS_W'(1);
                  end
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      text_len_q  <= '0;
      zero_seen_q <= 1'b0;
      match_q     <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      text_len_q  <= text_len_d;
      zero_seen_q <= zero_seen_d;
      match_q     <= match_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_cmd_q <= out_cmd_d;
    out_len_q <= out_len_d;
  end

  assign out_valid_o      = out_valid_q;
  assign command_o        = out_cmd_q;
  assign message_length_o = out_len_q;

endmodule

// ===== hdl/framed_command_keyword_decoder_unit.sv =====
// Top level of the framed command keyword decoder.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+----------------------------------
//   input    | in_valid_i / in_ready_o  | rx_byte_i
//   output   | out_valid_o / out_ready_i| command_o, message_length_o
//
// One item per cycle is sustained unless a closing item waits on a stalled
// result: the classifier pushes into a small queue, the engine pops from it.
// An accepted '#' goes through the queue and then the result register.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled result only blocks the engine when the next item closes a frame;
// other items keep flowing until the queue fills and in_ready_o drops.
module framed_command_keyword_decoder_unit #(
  parameter int unsigned MAX_LEN     = fckd_pkg::MAX_LEN_DEFAULT,
  parameter int unsigned QUEUE_DEPTH = fckd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [fckd_pkg::CMD_W-1:0]  command_o,
  output logic [fckd_pkg::LEN_W-1:0]  message_length_o
);
  import fckd_pkg::*;

  logic  q_push, q_full, q_valid, q_pop;
  item_t q_witem, q_ritem;

  fckd_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_witem)
  );

  fckd_queue #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_witem),
    .full_o  (q_full),
    .valid_o (q_valid),
    .rdata_o (q_ritem),
    .pop_i   (q_pop)
  );

  fckd_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_item_i         (q_ritem),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .command_o        (command_o),
    .message_length_o (message_length_o)
  );

  // A new result only appears after a '#' left the queue
  a_result_after_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(q_pop && q_ritem.kind == KIND_END))
    else $error("result without a closing delimiter");

  // A recognized command never reports fewer bytes than its keyword
  a_cmd_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && MAX_LEN < 32) |->
      ((command_o == CMD_UNKNOWN) ||
       (command_o == CMD_GOBACK    && message_length_o >= 5'd6) ||
       (command_o == CMD_GOAHEAD   && message_length_o >= 5'd7) ||
       (command_o == CMD_TURNLEFT  && message_length_o >= 5'd8) ||
       (command_o == CMD_TURNRIGHT && message_length_o >= 5'd9)))
    else $error("command and length disagree");

  // Reported length stays within the store
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && MAX_LEN < 32) |-> (message_length_o <= LEN_W'(MAX_LEN)))
    else $error("length beyond store size");

  // The engine never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (q_valid && !(q_push && q_full)))
    else $error("queue underflow");

endmodule

// ===== sim/framed_command_keyword_decoder_unit_tb.sv =====
// Testbench for the framed command keyword decoder: framed byte streams in, decoded commands out.
`timescale 1ns / 100ps

module framed_command_keyword_decoder_unit_tb;
  import fckd_pkg::*;

  localparam int MSG_MAX        = MAX_LEN_DEFAULT;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 1050;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [CMD_W-1:0] command;
    logic [LEN_W-1:0] length;
  } decode_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [7:0]       rx_byte_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [CMD_W-1:0] command_o;
  logic [LEN_W-1:0] message_length_o;

  // Decoder state as predicted from the accepted bytes
  logic             frame_open;
  int               frame_count;
  logic [7:0]       frame_buf [MSG_MAX];
  decode_t          pending_cmds[$];

  string            kw_text [4] = '{"goback", "goahead", "turnleft", "turnright"};
  logic [CMD_W-1:0] kw_code [4] = '{CMD_GOBACK, CMD_GOAHEAD, CMD_TURNLEFT, CMD_TURNRIGHT};

  int error_count;
  int items_sent;
  bit idle_en;
  int hold_off_cycles;

  framed_command_keyword_decoder_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .command_o        (command_o),
    .message_length_o (message_length_o)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Data byte that is never a delimiter; zero shows up often
  function automatic logic [7:0] data_byte();
    logic [7:0] b;
    if ($urandom_range(0, 7) == 0) return 8'h00;
    do b = 8'($urandom_range(0, 255)); while (b == BYTE_START || b == BYTE_END);
    return b;
  endfunction

  function automatic byte_q_t keyword_bytes(input int k);
    byte_q_t body;
    for (int p = 0; p < kw_text[k].len(); p++) body.push_back(kw_text[k][p]);
    return body;
  endfunction

  // Update the predicted state with one accepted byte; queue a result on close
  function automatic void decode_rx_byte(input logic [7:0] value);
    decode_t res;
    int      text_len;
    logic    hit;
    if (!frame_open) begin
      if (value == BYTE_START) begin
        frame_open  = 1'b1;
        frame_count = 0;
        foreach (frame_buf[i]) frame_buf[i] = 8'h00;
      end
    end else if (value == BYTE_END) begin
      text_len = 0;
      while (text_len < frame_count && frame_buf[text_len] != 8'h00) text_len++;
      res.command = CMD_UNKNOWN;
      for (int k = 0; k < 4; k++) begin
        if (res.command == CMD_UNKNOWN && kw_text[k].len() == text_len) begin
          hit = 1'b1;
          for (int p = 0; p < text_len; p++) begin
            if (frame_buf[p] != kw_text[k][p]) hit = 1'b0;
          end
          if (hit) res.command = kw_code[k];
        end
      end
      res.length = LEN_W'(frame_count);
      pending_cmds.push_back(res);
      frame_open  = 1'b0;
      frame_count = 0;
    end else if (value != BYTE_START) begin
      if (frame_count >= MSG_MAX) begin
        // Overlong frame: drop it without a result
        frame_open  = 1'b0;
        frame_count = 0;
        foreach (frame_buf[i]) frame_buf[i] = 8'h00;
      end else begin
        frame_buf[frame_count] = value;
        frame_count++;
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // Predict on input handshakes, check on output handshakes
  always @(posedge clk_i) begin : check_proc
    decode_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) decode_rx_byte(rx_byte_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_cmds.size() == 0) begin
          report_mismatch($sformatf("result with none expected: command %0d length %0d",
                                    command_o, message_length_o));
        end else begin
          want = pending_cmds.pop_front();
          if (command_o !== want.command)
            report_mismatch($sformatf("command: expected %0d, got %0d",
                                      want.command, command_o));
          if (message_length_o !== want.length)
            report_mismatch($sformatf("message_length: expected %0d, got %0d",
                                      want.length, message_length_o));
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : sink_proc
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_off_cycles--;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = idle_gap();
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin : watchdog_proc
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("framed_command_keyword_decoder_unit_tb failed");
        $finish;
      end
    end
  end

  // Offer one item, with a random gap ahead of it; hold until accepted
  task automatic send_item(input logic [7:0] value);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    rx_byte_i  <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_frame(input byte_q_t body);
    send_item(BYTE_START);
    foreach (body[i]) send_item(body[i]);
    send_item(BYTE_END);
  endtask

  // Drop valid, then hold until every predicted result is out
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
  endtask

  // Keywords, near misses, delimiters, zero bytes, full and overlong frames
  task automatic test_directed();
    byte_q_t body;
    idle_en = 1'b0;
    // bytes outside a frame are dropped, including a close
    send_item(8'h00);
    send_item(8'hFF);
    send_item(BYTE_END);
    send_frame(body);
    for (int k = 0; k < 4; k++) send_frame(keyword_bytes(k));
    body = keyword_bytes(3);
    void'(body.pop_back());
    send_frame(body);
    body = keyword_bytes(0);
    body.push_back("k");
    send_frame(body);
    // a second start inside a frame is ignored
    body = keyword_bytes(0);
    body.insert(2, BYTE_START);
    send_frame(body);
    // compare stops at the first zero byte, length counts everything
    body = keyword_bytes(0);
    body.push_back(8'h00);
    body.push_back(8'hFF);
    send_frame(body);
    body.delete();
    body.push_back(8'h00);
    body.push_back("g");
    send_frame(body);
    // full store, no zero byte
    body.delete();
    repeat (MSG_MAX) body.push_back(8'hFF);
    send_frame(body);
    // one byte too many: abort, the close then falls outside a frame
    body.delete();
    for (int i = 0; i <= MSG_MAX; i++) body.push_back(i[0] ? 8'hFF : 8'h00);
    send_frame(body);
    send_frame(keyword_bytes(2));
    idle_en = 1'b1;
    wait_for_results();
  endtask

  // Hold the receiver off while frames keep coming, so the input stalls
  task automatic test_output_stall();
    byte_q_t body;
    idle_en = 1'b0;
    hold_off_cycles = 300;
    repeat (12) begin
      send_frame(body);
      send_frame(keyword_bytes($urandom_range(0, 3)));
    end
    idle_en = 1'b1;
    wait_for_results();
  endtask

  // Pause the sender until every result is out, then go on
  task automatic test_drain_pause();
    repeat (3) send_frame(keyword_bytes($urandom_range(0, 3)));
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_for_results();
    repeat (3) send_frame(keyword_bytes($urandom_range(0, 3)));
    wait_for_results();
  endtask

  function automatic byte_q_t random_body();
    byte_q_t body;
    int      kind;
    int      n;
    kind = $urandom_range(0, 99);
    body = keyword_bytes($urandom_range(0, 3));
    if (kind < 35) begin
      // exact keyword
    end else if (kind < 50) begin
      body[$urandom_range(0, body.size() - 1)] = data_byte();
    end else if (kind < 58) begin
      if ($urandom_range(0, 1)) void'(body.pop_back());
      else body.push_back(data_byte());
    end else if (kind < 66) begin
      body.push_back(8'h00);
      n = $urandom_range(0, MSG_MAX - body.size());
      repeat (n) body.push_back(data_byte());
    end else if (kind < 76) begin
      body.delete();
      n = $urandom_range(0, MSG_MAX);
      repeat (n) body.push_back(data_byte());
    end else if (kind < 84) begin
      body.delete();
      n = $urandom_range(MSG_MAX + 1, MSG_MAX + 4);
      repeat (n) body.push_back(data_byte());
    end else if (kind < 90) begin
      body.delete();
      repeat (MSG_MAX) body.push_back(data_byte());
    end else begin
      body.insert($urandom_range(0, body.size()), BYTE_START);
    end
    return body;
  endfunction

  // Mostly well-formed frames with random content, some noise between them
  task automatic test_random_frames();
    int first_item;
    int n;
    logic [7:0] b;
    first_item = items_sent;
    idle_en = 1'b1;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) idle_en = !idle_en;
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          do b = 8'($urandom_range(0, 255)); while (b == BYTE_START);
          send_item(b);
        end
      end
      send_frame(random_body());
    end
    idle_en = 1'b1;
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    rx_byte_i       = 8'h00;
    out_ready_i     = 1'b0;
    error_count     = 0;
    items_sent      = 0;
    idle_en         = 1'b1;
    hold_off_cycles = 0;
    frame_open      = 1'b0;
    frame_count     = 0;
    foreach (frame_buf[i]) frame_buf[i] = 8'h00;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_output_stall();
    test_drain_pause();
    test_random_frames();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_for_results();
    repeat (10) @(posedge clk_i);

    if (error_count == 0) begin
      $display("framed_command_keyword_decoder_unit_tb passed");
    end else begin
      $display("framed_command_keyword_decoder_unit_tb failed");
    end
    $finish;
  end

endmodule

// ===== framed_command_keyword_decoder_unit.f =====
hdl/fckd_pkg.sv
hdl/fckd_front.sv
hdl/fckd_queue.sv
hdl/fckd_back.sv
hdl/framed_command_keyword_decoder_unit.sv
sim/framed_command_keyword_decoder_unit_tb.sv
